### hw/rtl/csp_pkg.sv
// Shared constants, register codes and CORDIC helpers for the cardioid arm servo planner.
// Used by csp_cordic_rot, csp_cordic_vec and cardioid_arm_servo_planner; depends on nothing.
package csp_pkg;

  localparam int CORDIC_STEPS_DEF        = 16;
  localparam int ANGLE_FRACTION_BITS_DEF = 16;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CURVE_SCALE    = 2'd0,
    REG_CURVE_OFFSET_X = 2'd1,
    REG_REACH_LIMIT    = 2'd2,
    REG_PULSE_BASE     = 2'd3
  } cfg_reg_t;

  localparam int ROT_W = 32;

  localparam int ARM_H = 56;
  localparam int LINK1 = 40;
  localparam int LINK2 = 65;
  localparam int LINK3 = 130;
  localparam int LINK4 = 93;

  localparam longint ELBOW_NUM_Q16 = 37232640;
  localparam longint ELBOW_Y       = ELBOW_NUM_Q16 * LINK3;
  localparam longint ELBOW_X0      = longint'(ARM_H + LINK1) * (ARM_H + LINK1) * 65536;
  localparam longint SHOULDER_K    = longint'(ARM_H + LINK1) * 65536;

  localparam longint CORDIC_K_Q30  = 652032874;
  localparam longint COS45_Q30     = 759250125;
  localparam longint PI_Q30        = 64'sd3373259426;
  localparam longint DEG2RAD_Q30   = 18740330;
  localparam longint DEG_PULSE_Q20 = 666876670;

  localparam logic signed [16:0] PT_MAX = 17'sh0FFFF;
  localparam logic signed [16:0] PT_MIN = 17'sh10000;

  function automatic longint rshr(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint atan_q30(int i);
    longint r;
    unique case (i)
      0:       r = 843314857;
      1:       r = 497837829;
      2:       r = 263043837;
      3:       r = 133525159;
      4:       r = 67021687;
      5:       r = 33543516;
      6:       r = 16775851;
      7:       r = 8388437;
      8:       r = 4194283;
      9:       r = 2097149;
      10:      r = 1048576;
      11:      r = 524288;
      12:      r = 262144;
      13:      r = 131072;
      14:      r = 65536;
      15:      r = 32768;
      16:      r = 16384;
      17:      r = 8192;
      18:      r = 4096;
      19:      r = 2048;
      20:      r = 1024;
      21:      r = 512;
      22:      r = 256;
      default: r = 128;
    endcase
    return r;
  endfunction

  function automatic longint atan_step(int i, int afb);
    return rshr(atan_q30(i), 30 - afb);
  endfunction

endpackage

### hw/rtl/csp_cordic_rot.sv
// Unrolled rotation CORDIC: one registered micro-rotation per stage, Q30 cos/sin out.
// Depends on csp_pkg.
module csp_cordic_rot #(
  parameter int STEPS = csp_pkg::CORDIC_STEPS_DEF,
  parameter int AFB   = csp_pkg::ANGLE_FRACTION_BITS_DEF
) (
  input  logic                             clk,
  input  logic signed [AFB+3:0]            z_in,
  output logic signed [csp_pkg::ROT_W-1:0] cos_q30,
  output logic signed [csp_pkg::ROT_W-1:0] sin_q30
);
  import csp_pkg::*;

  localparam int ZW = AFB + 4;

  logic signed [ROT_W-1:0] xs [STEPS];
  logic signed [ROT_W-1:0] ys [STEPS];
  logic signed [ZW-1:0]    zs [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [ZW-1:0] ATAN = ZW'(atan_step(i, AFB));
    logic signed [ROT_W-1:0] x_cur;
    logic signed [ROT_W-1:0] y_cur;
    logic signed [ZW-1:0]    z_cur;
    if (i == 0) begin : g_first
      assign x_cur = ROT_W'(CORDIC_K_Q30);
      assign y_cur = '0;
      assign z_cur = z_in;
    end else begin : g_next
      assign x_cur = xs[i-1];
      assign y_cur = ys[i-1];
      assign z_cur = zs[i-1];
    end
    always_ff @(posedge clk) begin
      if (z_cur >= 0) begin
        xs[i] <= x_cur - (y_cur >>> i);
        ys[i] <= y_cur + (x_cur >>> i);
        zs[i] <= z_cur - ATAN;
      end else begin
        xs[i] <= x_cur + (y_cur >>> i);
        ys[i] <= y_cur - (x_cur >>> i);
        zs[i] <= z_cur + ATAN;
      end
    end
  end

  assign cos_q30 = xs[STEPS-1];
  assign sin_q30 = ys[STEPS-1];

endmodule

### hw/rtl/csp_cordic_vec.sv
// Unrolled vectoring CORDIC for atan2: a quadrant stage, then one registered step per stage.
// Depends on csp_pkg.
module csp_cordic_vec #(
  parameter int STEPS = csp_pkg::CORDIC_STEPS_DEF,
  parameter int AFB   = csp_pkg::ANGLE_FRACTION_BITS_DEF,
  parameter int W     = 36
) (
  input  logic                  clk,
  input  logic signed [W-1:0]   x_in,
  input  logic signed [W-1:0]   y_in,
  output logic signed [AFB+3:0] angle
);
  import csp_pkg::*;

  localparam int ZW = AFB + 4;
  localparam logic signed [ZW-1:0] PI_POS = ZW'(rshr(PI_Q30, 30 - AFB));
  localparam logic signed [ZW-1:0] PI_NEG = ZW'(rshr(-PI_Q30, 30 - AFB));

  logic signed [W-1:0]  x0;
  logic signed [W-1:0]  y0;
  logic signed [ZW-1:0] z0;
  logic                 zero0;

  logic signed [W-1:0]  xs [STEPS];
  logic signed [W-1:0]  ys [STEPS];
  logic signed [ZW-1:0] zs [STEPS];
  logic                 zero_q [STEPS];

  always_ff @(posedge clk) begin
    zero0 <= (x_in == '0) && (y_in == '0);
    if (x_in < 0) begin
      x0 <= -x_in;
      y0 <= -y_in;
      z0 <= (y_in >= 0) ? PI_POS : PI_NEG;
    end else begin
      x0 <= x_in;
      y0 <= y_in;
      z0 <= '0;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [ZW-1:0] ATAN = ZW'(atan_step(i, AFB));
    logic signed [W-1:0]  x_cur;
    logic signed [W-1:0]  y_cur;
    logic signed [ZW-1:0] z_cur;
    logic                 zero_cur;
    if (i == 0) begin : g_first
      assign x_cur    = x0;
      assign y_cur    = y0;
      assign z_cur    = z0;
      assign zero_cur = zero0;
    end else begin : g_next
      assign x_cur    = xs[i-1];
      assign y_cur    = ys[i-1];
      assign z_cur    = zs[i-1];
      assign zero_cur = zero_q[i-1];
    end
    always_ff @(posedge clk) begin
      zero_q[i] <= zero_cur;
      if (y_cur > 0) begin
        xs[i] <= x_cur + (y_cur >>> i);
        ys[i] <= y_cur - (x_cur >>> i);
        zs[i] <= z_cur + ATAN;
      end else begin
        xs[i] <= x_cur - (y_cur >>> i);
        ys[i] <= y_cur + (x_cur >>> i);
        zs[i] <= z_cur - ATAN;
      end
    end
  end

  assign angle = zero_q[STEPS-1] ? '0 : zs[STEPS-1];

endmodule

### hw/rtl/cardioid_arm_servo_planner.sv
// Top level: cardioid point, rotation, three-joint inverse kinematics and servo pulses.
// Depends on csp_pkg, csp_cordic_rot and csp_cordic_vec.
//
// One angle is taken in every clock cycle and busy never rises. Each transaction comes out
// on done after passing the angle rotation CORDIC, then the base and elbow atan2 CORDICs
// side by side, the elbow one in series with the joint-three rotation CORDIC (or the
// 25-stage square root if longer), and then the shoulder atan2 CORDIC. Results are
// presented for one cycle only: the receiver has to take every done pulse. Configuration
// must be written only while no transaction is in flight.
module cardioid_arm_servo_planner #(
  parameter int CORDIC_STEPS        = csp_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRACTION_BITS = csp_pkg::ANGLE_FRACTION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [8:0]                       angle_deg,
  input  logic                             wr_en,
  input  logic [csp_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [csp_pkg::CFG_W-1:0]        wr_data,
  output logic                             done,
  output logic signed [16:0]               point_x,
  output logic signed [16:0]               point_y,
  output logic signed [12:0]               base_pulse,
  output logic signed [12:0]               shoulder_pulse,
  output logic signed [12:0]               elbow_pulse,
  output logic                             out_of_reach
);
  import csp_pkg::*;

  localparam int N    = CORDIC_STEPS;
  localparam int AFB  = ANGLE_FRACTION_BITS;
  localparam int ZW   = AFB + 4;
  localparam int PW   = ZW + 31;
  localparam int SH   = AFB + 20;
  localparam int W1   = 36;
  localparam int W3   = 37;
  localparam int W2   = 55;
  localparam int SQRT_STAGES = 25;
  localparam int S    = N + 11;
  localparam int MAXA = (2 * N + 2 > SQRT_STAGES) ? 2 * N + 2 : SQRT_STAGES;
  localparam int T2   = S + MAXA + N + 5;
  localparam int LAT  = T2 + 2;
  localparam int DA   = MAXA - 2 * N - 1;
  localparam int DQ   = MAXA + 1 - SQRT_STAGES;
  localparam int D13  = MAXA + 4;
  localparam int DP   = T2 + 1 - S;
  localparam longint ZHALF = longint'(1) << (29 - AFB);

  logic [7:0]  curve_scale;
  logic [9:0]  curve_offset_x;
  logic [9:0]  reach_limit;
  logic [10:0] pulse_base;
  logic        accept;
  logic [LAT-1:0] vld;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign done   = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_scale    <= 8'd15;
      curve_offset_x <= 10'd155;
      reach_limit    <= 10'd195;
      pulse_base     <= 11'd500;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_CURVE_SCALE:    curve_scale    <= wr_data[7:0];
        REG_CURVE_OFFSET_X: curve_offset_x <= wr_data[9:0];
        REG_REACH_LIMIT:    reach_limit    <= wr_data[9:0];
        REG_PULSE_BASE:     pulse_base     <= wr_data[10:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], accept};
    end
  end

  // fold the angle into -90..90 degrees
  logic signed [10:0] d_a;
  logic signed [10:0] d_b;
  logic               flip_c;
  always_comb begin
    d_a    = $signed({2'b00, angle_deg});
    flip_c = 1'b0;
    if (d_a >= 11'sd360) d_a = d_a - 11'sd360;
    if (d_a > 11'sd180) d_a = d_a - 11'sd360;
    d_b = d_a;
    if (d_a > 11'sd90) begin
      d_b    = d_a - 11'sd180;
      flip_c = 1'b1;
    end else if (d_a < -11'sd90) begin
      d_b    = d_a + 11'sd180;
      flip_c = 1'b1;
    end
  end

  logic signed [7:0]    d1;
  logic                 flip1;
  logic signed [ZW-1:0] z2;
  logic                 flip2;
  logic signed [33:0]   zp;

  assign zp = 34'(d1) * 34'(DEG2RAD_Q30);

  always_ff @(posedge clk) begin
    d1    <= d_b[7:0];
    flip1 <= flip_c;
    z2    <= ZW'((zp + 34'(ZHALF)) >>> (30 - AFB));
    flip2 <= flip1;
  end

  logic signed [ROT_W-1:0] c30;
  logic signed [ROT_W-1:0] s30;

  csp_cordic_rot #(.STEPS(N), .AFB(AFB)) u_rot_curve (
    .clk     (clk),
    .z_in    (z2),
    .cos_q30 (c30),
    .sin_q30 (s30)
  );

  logic flip_q [N];
  always_ff @(posedge clk) begin
    flip_q[0] <= flip2;
    for (int k = 1; k < N; k++) flip_q[k] <= flip_q[k-1];
  end

  // cardioid point and 45 degree rotation
  logic signed [32:0] cf;
  logic signed [32:0] sf;
  logic signed [17:0] c16;
  logic signed [17:0] s16;
  logic signed [26:0] m1;
  logic signed [26:0] m2;
  logic signed [18:0] w2;
  logic signed [44:0] xp;
  logic signed [44:0] yp;
  logic signed [27:0] x16;
  logic signed [27:0] y16;
  logic signed [28:0] dxy;
  logic signed [28:0] sxy;
  logic signed [59:0] pd;
  logic signed [59:0] ps;
  logic signed [21:0] rx;
  logic signed [21:0] ry;
  logic signed [16:0] px7;
  logic signed [16:0] py7;

  assign cf = flip_q[N-1] ? -33'(c30) : 33'(c30);
  assign sf = flip_q[N-1] ? -33'(s30) : 33'(s30);
  assign rx = 22'((pd + (60'sd1 <<< 37)) >>> 38);
  assign ry = 22'((ps + (60'sd1 <<< 37)) >>> 38);

  always_ff @(posedge clk) begin
    c16 <= 18'((cf + 33'sd8192) >>> 14);
    s16 <= 18'((sf + 33'sd8192) >>> 14);
    m1  <= 27'(c16) * 27'($signed({1'b0, curve_scale}));
    m2  <= 27'(s16) * 27'($signed({1'b0, curve_scale}));
    w2  <= 19'(c16) + 19'sd65536;
    xp  <= 45'(m1) * 45'(w2);
    yp  <= 45'(m2) * 45'(w2);
    x16 <= 28'((xp + 45'sd32768) >>> 16) + $signed({2'b00, curve_offset_x, 16'h0000});
    y16 <= 28'((yp + 45'sd32768) >>> 16);
    dxy <= 29'(x16) - 29'(y16);
    sxy <= 29'(x16) + 29'(y16);
    pd  <= 60'(dxy) * 60'(COS45_Q30);
    ps  <= 60'(sxy) * 60'(COS45_Q30);
    px7 <= (rx > 22'(PT_MAX)) ? PT_MAX : (rx < 22'(PT_MIN)) ? PT_MIN : rx[16:0];
    py7 <= (ry > 22'(PT_MAX)) ? PT_MAX : (ry < 22'(PT_MIN)) ? PT_MIN : ry[16:0];
  end

  // squared distance and reach check
  logic [33:0]        pxx;
  logic [33:0]        pyy;
  logic [19:0]        rr8;
  logic signed [16:0] px8;
  logic signed [16:0] py8;
  logic [33:0]        sq9;
  logic               oor9;
  logic signed [16:0] px9;
  logic signed [16:0] py9;

  always_ff @(posedge clk) begin
    pxx  <= 34'(35'(px7) * 35'(px7));
    pyy  <= 34'(35'(py7) * 35'(py7));
    rr8  <= 20'(reach_limit) * 20'(reach_limit);
    px8  <= px7;
    py8  <= py7;
    sq9  <= pxx + pyy;
    oor9 <= {2'b00, pxx} + {2'b00, pyy} > {rr8, 16'h0000};
    px9  <= px8;
    py9  <= py8;
  end

  // base and elbow angles
  logic signed [W1-1:0] v1x;
  logic signed [W1-1:0] v1y;
  logic signed [W3-1:0] v3x;
  logic signed [W3-1:0] v3y;
  logic signed [ZW-1:0] z1;
  logic signed [ZW-1:0] z3;

  assign v1x = W1'($signed({px9, 16'h0000}));
  assign v1y = W1'($signed({py9, 16'h0000}));
  assign v3x = $signed({3'b000, sq9}) + W3'(ELBOW_X0);
  assign v3y = W3'(ELBOW_Y);

  csp_cordic_vec #(.STEPS(N), .AFB(AFB), .W(W1)) u_vec_base (
    .clk   (clk),
    .x_in  (v1x),
    .y_in  (v1y),
    .angle (z1)
  );

  csp_cordic_vec #(.STEPS(N), .AFB(AFB), .W(W3)) u_vec_elbow (
    .clk   (clk),
    .x_in  (v3x),
    .y_in  (v3y),
    .angle (z3)
  );

  logic signed [ROT_W-1:0] c30b;
  logic signed [ROT_W-1:0] s30b;
  logic signed [17:0]      c16b;
  logic signed [17:0]      s16b;

  csp_cordic_rot #(.STEPS(N), .AFB(AFB)) u_rot_elbow (
    .clk     (clk),
    .z_in    (z3),
    .cos_q30 (c30b),
    .sin_q30 (s30b)
  );

  always_ff @(posedge clk) begin
    c16b <= 18'((33'(c30b) + 33'sd8192) >>> 14);
    s16b <= 18'((33'(s30b) + 33'sd8192) >>> 14);
  end

  // floor square root of sq << 16, two radicand bits per stage
  logic [49:0] sq_v    [SQRT_STAGES];
  logic [26:0] sq_rem  [SQRT_STAGES];
  logic [24:0] sq_root [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    logic [49:0] v_cur;
    logic [26:0] rem_cur;
    logic [24:0] root_cur;
    logic [26:0] rem_sh;
    logic [26:0] trial;
    if (k == 0) begin : g_first
      assign v_cur    = {sq9, 16'h0000};
      assign rem_cur  = '0;
      assign root_cur = '0;
    end else begin : g_next
      assign v_cur    = sq_v[k-1];
      assign rem_cur  = sq_rem[k-1];
      assign root_cur = sq_root[k-1];
    end
    assign rem_sh = {rem_cur[24:0], v_cur[49:48]};
    assign trial  = {root_cur, 2'b01};
    always_ff @(posedge clk) begin
      sq_v[k] <= {v_cur[47:0], 2'b00};
      if (rem_sh >= trial) begin
        sq_rem[k]  <= rem_sh - trial;
        sq_root[k] <= {root_cur[23:0], 1'b1};
      end else begin
        sq_rem[k]  <= rem_sh;
        sq_root[k] <= {root_cur[23:0], 1'b0};
      end
    end
  end

  // align the elbow rotation and the root
  logic [35:0] cs_q [DA];
  logic [24:0] r_q  [DQ];
  always_ff @(posedge clk) begin
    cs_q[0] <= {c16b, s16b};
    for (int k = 1; k < DA; k++) cs_q[k] <= cs_q[k-1];
    r_q[0] <= sq_root[SQRT_STAGES-1];
    for (int k = 1; k < DQ; k++) r_q[k] <= r_q[k-1];
  end

  // shoulder angle operands
  logic signed [17:0] c16j;
  logic signed [17:0] s16j;
  logic signed [25:0] ah;
  logic signed [25:0] bh;
  logic [24:0]        rh;
  logic signed [51:0] ar;
  logic signed [51:0] br;
  logic signed [25:0] ai;
  logic signed [25:0] bi;
  logic signed [51:0] y2;
  logic signed [51:0] x2;

  assign c16j = $signed(cs_q[DA-1][35:18]);
  assign s16j = $signed(cs_q[DA-1][17:0]);

  always_ff @(posedge clk) begin
    ah <= 26'(LINK2 * 65536) + 26'(c16j) * 26'(LINK3) - 26'(s16j) * 26'(LINK4);
    bh <= 26'(s16j) * 26'(LINK3) + 26'(c16j) * 26'(LINK4);
    rh <= r_q[DQ-1];
    ar <= 52'(ah) * 52'($signed({1'b0, rh}));
    br <= 52'(bh) * 52'($signed({1'b0, rh}));
    ai <= ah;
    bi <= bh;
    y2 <= ar + 52'(bi) * 52'(SHOULDER_K);
    x2 <= br - 52'(ai) * 52'(SHOULDER_K);
  end

  logic signed [ZW-1:0] z2s;

  csp_cordic_vec #(.STEPS(N), .AFB(AFB), .W(W2)) u_vec_shoulder (
    .clk   (clk),
    .x_in  (W2'(x2)),
    .y_in  (W2'(y2)),
    .angle (z2s)
  );

  logic [2*ZW-1:0] t13_q [D13];
  logic [34:0]     pxo_q [DP];
  always_ff @(posedge clk) begin
    t13_q[0] <= {z1, z3};
    for (int k = 1; k < D13; k++) t13_q[k] <= t13_q[k-1];
    pxo_q[0] <= {px9, py9, oor9};
    for (int k = 1; k < DP; k++) pxo_q[k] <= pxo_q[k-1];
  end

  // pulses: base plus degrees times 11.1, truncated toward zero
  function automatic logic signed [13:0] pulse_trunc(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] mag;
    mag = (p < 0) ? -p : p;
    mag = mag >>> SH;
    return (p < 0) ? -14'(mag) : 14'(mag);
  endfunction

  logic signed [PW-1:0] pk1;
  logic signed [PW-1:0] pk2;
  logic signed [PW-1:0] pk3;
  logic signed [13:0]   base14;

  assign base14 = $signed({3'b000, pulse_base});

  always_ff @(posedge clk) begin
    pk1 <= PW'($signed(t13_q[D13-1][2*ZW-1:ZW])) * PW'(DEG_PULSE_Q20);
    pk2 <= PW'(z2s) * PW'(DEG_PULSE_Q20);
    pk3 <= PW'($signed(t13_q[D13-1][ZW-1:0])) * PW'(DEG_PULSE_Q20);
    base_pulse     <= 13'(base14 + pulse_trunc(pk1));
    shoulder_pulse <= 13'(base14 + pulse_trunc(pk2));
    elbow_pulse    <= 13'(base14 + pulse_trunc(pk3));
    point_x        <= $signed(pxo_q[DP-1][34:18]);
    point_y        <= $signed(pxo_q[DP-1][17:1]);
    out_of_reach   <= pxo_q[DP-1][0];
  end

  a_done_after_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a matching transaction");

  a_origin_in_reach: assert property (@(posedge clk) disable iff (rst)
    done && point_x == 17'sd0 && point_y == 17'sd0 |-> !out_of_reach)
    else $error("origin flagged out of reach");

  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result straight after reset");

endmodule

### tb/tb_cardioid_arm_servo_planner.sv
// Self-checking testbench for cardioid_arm_servo_planner: directed angles, register extremes
// and random bursts, each result checked against a local fixed-point predictor.
// Depends on csp_pkg (register index codes) and the planner RTL.
module tb_cardioid_arm_servo_planner;
  timeunit 1ns;
  timeprecision 1ps;
  import csp_pkg::*;

  localparam int     STEPS      = 16;
  localparam int     AFB        = 16;
  localparam int     LATENCY    = 84;
  localparam longint CYCLE_CAP  = 400000;
  localparam longint K_Q30      = 652032874;
  localparam longint C45_Q30    = 759250125;
  localparam longint PI_Q30_C   = 64'sd3373259426;
  localparam longint D2R_Q30    = 18740330;
  localparam longint PULSE_Q20  = 666876670;
  localparam longint ELBOW_Q16  = 37232640;
  localparam longint ARM_REACH  = 96;
  localparam longint L2 = 65, L3 = 130, L4 = 93;
  localparam longint ATAN_TAB [16] = '{843314857, 497837829, 263043837, 133525159,
    67021687, 33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768};

  typedef struct packed {
    logic signed [16:0] px;
    logic signed [16:0] py;
    logic signed [12:0] p_base;
    logic signed [12:0] p_shoulder;
    logic signed [12:0] p_elbow;
    logic               far;
  } servo_cmd_t;

  logic clk, rst, start, busy, wr_en, done;
  logic [8:0] angle_deg;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [CFG_W-1:0] wr_data;
  logic signed [16:0] point_x, point_y;
  logic signed [12:0] base_pulse, shoulder_pulse, elbow_pulse;
  logic out_of_reach;

  cardioid_arm_servo_planner dut (.*);

  longint scale_r, offset_r, reach_r, pbase_r;
  servo_cmd_t pending_cmds[$];
  int errors, sent, checked;
  longint cycles;

  function automatic longint rnd_shr(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint atan_inc(int i);
    return rnd_shr(ATAN_TAB[i], 30 - AFB);
  endfunction

  function automatic void rotate(longint z, output longint c, output longint s);
    longint x, y, nx, ny;
    x = K_Q30; y = 0;
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_inc(i);
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += atan_inc(i);
      end
      x = nx; y = ny;
    end
    c = x; s = y;
  endfunction

  function automatic longint vec_atan2(longint y, longint x);
    longint z, nx, ny;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = rnd_shr(y >= 0 ? PI_Q30_C : -PI_Q30_C, 30 - AFB);
      x = -x; y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += atan_inc(i);
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_inc(i);
      end
      x = nx; y = ny;
    end
    return z;
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned res, bit_v;
    res = 0; bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v -= res + bit_v; res = (res >> 1) + bit_v;
      end else res >>= 1;
      bit_v >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic logic signed [12:0] joint_pulse(longint z);
    longint p, t;
    p = z * PULSE_Q20;
    t = (p >= 0) ? (p >>> (AFB + 20)) : -((-p) >>> (AFB + 20));
    return 13'(pbase_r + t);
  endfunction

  function automatic longint clamp_pt(longint v);
    if (v > 65535) return 65535;
    if (v < -65536) return -65536;
    return v;
  endfunction

  function automatic servo_cmd_t plan_servos(logic [8:0] ang);
    servo_cmd_t r;
    longint d, c30, s30, c16, s16, x16, y16, px, py, sq, t1, t2, t3, a, b, r16, y2, x2;
    bit flip;
    d = ang; flip = 0;
    if (d >= 360) d -= 360;
    if (d > 180) d -= 360;
    if (d > 90) begin
      d -= 180; flip = 1;
    end else if (d < -90) begin
      d += 180; flip = 1;
    end
    rotate(rnd_shr(d * D2R_Q30, 30 - AFB), c30, s30);
    if (flip) begin
      c30 = -c30; s30 = -s30;
    end
    c16 = rnd_shr(c30, 14);
    s16 = rnd_shr(s30, 14);
    x16 = rnd_shr(scale_r * c16 * (65536 + c16), 16) + offset_r * 65536;
    y16 = rnd_shr(scale_r * s16 * (65536 + c16), 16);
    px = clamp_pt(rnd_shr((x16 - y16) * C45_Q30, 38));
    py = clamp_pt(rnd_shr((x16 + y16) * C45_Q30, 38));
    sq = px * px + py * py;
    t1 = vec_atan2(py * 65536, px * 65536);
    t3 = vec_atan2(ELBOW_Q16 * L3, sq + ARM_REACH * ARM_REACH * 65536);
    rotate(t3, c30, s30);
    c16 = rnd_shr(c30, 14);
    s16 = rnd_shr(s30, 14);
    r16 = floor_sqrt(longint'(sq) << 16);
    a = L2 * 65536 + L3 * c16 - L4 * s16;
    b = L3 * s16 + L4 * c16;
    y2 = a * r16 + ARM_REACH * 65536 * b;
    x2 = b * r16 - ARM_REACH * 65536 * a;
    t2 = vec_atan2(y2, x2);
    r.px = 17'(px);
    r.py = 17'(py);
    r.p_base = joint_pulse(t1);
    r.p_shoulder = joint_pulse(t2);
    r.p_elbow = joint_pulse(t3);
    r.far = sq > reach_r * reach_r * 65536;
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    servo_cmd_t exp_c;
    if (!rst && done) begin
      if (pending_cmds.size() == 0) begin
        errors++;
        $display("%0t: unexpected result x=%0d y=%0d", $time, point_x, point_y);
      end else begin
        exp_c = pending_cmds.pop_front();
        checked++;
        if (exp_c.px !== point_x || exp_c.py !== point_y || exp_c.p_base !== base_pulse ||
            exp_c.p_shoulder !== shoulder_pulse || exp_c.p_elbow !== elbow_pulse ||
            exp_c.far !== out_of_reach) begin
          errors++;
          $display("%0t: mismatch exp x=%0d y=%0d b=%0d s=%0d e=%0d f=%0b", $time,
                   exp_c.px, exp_c.py, exp_c.p_base, exp_c.p_shoulder, exp_c.p_elbow,
                   exp_c.far);
          $display("%0t:          got x=%0d y=%0d b=%0d s=%0d e=%0d f=%0b", $time,
                   point_x, point_y, base_pulse, shoulder_pulse, elbow_pulse,
                   out_of_reach);
        end
      end
    end
  end

  task automatic send_angle(logic [8:0] ang);
    @(negedge clk);
    start <= 1;
    angle_deg <= ang;
    do @(posedge clk); while (busy);
    pending_cmds.push_back(plan_servos(ang));
    sent++;
  endtask

  task automatic pause_sender(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 0;
      angle_deg <= 9'($urandom);
    end
  endtask

  task automatic drain();
    pause_sender(1);
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (LATENCY + 6) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, longint val);
    @(negedge clk);
    wr_en <= 1;
    wr_index <= idx;
    wr_data <= CFG_W'(val);
    @(negedge clk);
    wr_en <= 0;
    case (idx)
      REG_CURVE_SCALE:    scale_r = val & 8'hFF;
      REG_CURVE_OFFSET_X: offset_r = val & 10'h3FF;
      REG_REACH_LIMIT:    reach_r = val & 10'h3FF;
      default:            pbase_r = val & 11'h7FF;
    endcase
  endtask

  task automatic set_config(longint sc, longint off, longint rl, longint pb);
    drain();
    write_reg(REG_CURVE_SCALE, sc);
    write_reg(REG_CURVE_OFFSET_X, off);
    write_reg(REG_REACH_LIMIT, rl);
    write_reg(REG_PULSE_BASE, pb);
  endtask

  task automatic test_directed_angles();
    int angs[] = '{0, 1, 45, 89, 90, 91, 135, 179, 180, 181, 225, 269, 270, 271, 315,
                   359, 360, 361, 450, 511, 256, 255};
    foreach (angs[i]) send_angle(9'(angs[i]));
  endtask

  task automatic test_register_extremes();
    set_config(0, 0, 0, 0);
    send_angle(0); send_angle(90); send_angle(180);
    set_config(255, 1023, 1023, 2047);
    send_angle(0); send_angle(45); send_angle(180); send_angle(300);
    set_config(255, 0, 0, 2047);
    send_angle(0); send_angle(120); send_angle(180); send_angle(240);
    set_config(1, 1023, 1023, 0);
    send_angle(0); send_angle(135); send_angle(511);
  endtask

  task automatic test_random_bursts(int total);
    int phase_left;
    phase_left = 0;
    while (total > 0) begin
      if (phase_left == 0) begin
        set_config($urandom_range(255), $urandom_range(1023), $urandom_range(1023),
                   $urandom_range(2047));
        phase_left = $urandom_range(150, 40);
      end
      repeat ($urandom_range(20, 1)) begin
        send_angle(9'($urandom));
        total--; phase_left--;
        if (total == 0 || phase_left == 0) break;
      end
      if ($urandom_range(3) != 0) pause_sender($urandom_range(6, 1));
    end
  endtask

  initial begin
    rst = 1; start = 0; angle_deg = 0; wr_en = 0; wr_index = REG_CURVE_SCALE; wr_data = 0;
    scale_r = 15; offset_r = 155; reach_r = 195; pbase_r = 500;
    errors = 0; sent = 0; checked = 0; cycles = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_directed_angles();
    test_register_extremes();
    test_random_bursts(900);
    drain();
    $display("Covered %0d angle transactions, %0d results checked, %0d errors,", sent,
             checked, errors);
    $display("across reset, extreme and random register settings.");
    if (errors == 0 && pending_cmds.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

### files.f
hw/rtl/csp_pkg.sv
hw/rtl/csp_cordic_rot.sv
hw/rtl/csp_cordic_vec.sv
hw/rtl/cardioid_arm_servo_planner.sv
tb/tb_cardioid_arm_servo_planner.sv
